// File: rtl/tqtp_pkg.sv
package tqtp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int QUAT_W          = 16;
    localparam int MAT_W           = 22;
    localparam int MAT_DROP        = 12;
    localparam int VERT_FRAC       = 8;
    localparam int OUT_W           = 16;
    localparam int QUO_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int OUT_DATA_W      = ((9 * OUT_W + 7) / 8) * 8;

    localparam logic [1:0]            CFG_HOLD   = 2'd2;
    localparam logic [CFG_DATA_W-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_QUAT = 3'd0,
        CFG_OFF_X    = 3'd1,
        CFG_OFF_Y    = 3'd2,
        CFG_OFF_Z    = 3'd3,
        CFG_FOCAL_X  = 3'd4,
        CFG_FOCAL_Y  = 3'd5,
        CFG_CENTER   = 3'd6,
        CFG_DEPTH    = 3'd7
    } t_cfg_idx;

    // rotation matrix, row major, entry 0 in the lowest bits
    typedef logic [8:0][MAT_W-1:0] t_mat;

    typedef struct packed {
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_z;
        logic [15:0]        focal_x;
        logic [15:0]        focal_y;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic signed [31:0] near_z;
        logic signed [31:0] far_z;
    } t_cam;

    typedef struct packed {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
        logic [OUT_W-1:0]        depth;
        logic                    vis;
    } t_lane_res;

endpackage

// File: rtl/tqtp_rot.sv
module tqtp_rot import tqtp_pkg::*; (
    input  logic                  i_clk,
    input  logic [CFG_DATA_W-1:0] i_quat,
    output t_mat                  o_mat
);

    logic signed [QUAT_W-1:0] qw, qx, qy, qz;
    logic signed [2*QUAT_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [2*QUAT_W+1:0] e [9];
    t_mat r_mat;

    assign qw = i_quat[63:48];
    assign qx = i_quat[47:32];
    assign qy = i_quat[31:16];
    assign qz = i_quat[15:0];

    always_ff @(posedge i_clk) begin
        r_ww <= qw * qw;
        r_xx <= qx * qx;
        r_yy <= qy * qy;
        r_zz <= qz * qz;
        r_xy <= qx * qy;
        r_wz <= qw * qz;
        r_xz <= qx * qz;
        r_wy <= qw * qy;
        r_yz <= qy * qz;
        r_wx <= qw * qx;
    end

    always_comb begin
        e[0] = 34'(r_ww) + 34'(r_xx) - 34'(r_yy) - 34'(r_zz);
        e[1] = (34'(r_xy) - 34'(r_wz)) <<< 1;
        e[2] = (34'(r_xz) + 34'(r_wy)) <<< 1;
        e[3] = (34'(r_xy) + 34'(r_wz)) <<< 1;
        e[4] = 34'(r_ww) - 34'(r_xx) + 34'(r_yy) - 34'(r_zz);
        e[5] = (34'(r_yz) - 34'(r_wx)) <<< 1;
        e[6] = (34'(r_xz) - 34'(r_wy)) <<< 1;
        e[7] = (34'(r_yz) + 34'(r_wx)) <<< 1;
        e[8] = 34'(r_ww) - 34'(r_xx) - 34'(r_yy) + 34'(r_zz);
    end

    // floor to Q.16
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_mat[i] <= MAT_W'(e[i] >>> MAT_DROP);
        end
    end

    assign o_mat = r_mat;

endmodule

// File: rtl/tqtp_div.sv
module tqtp_div import tqtp_pkg::*; #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 32,
    parameter int QB    = QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QB-1:0]    o_quo,
    output logic             o_rem_nz,
    output logic             o_ovf
);

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] r_rem [0:QB];
    logic [QB-1:0]    r_quo [0:QB];
    logic             r_ovf [0:QB];
    logic [QB-1:0]    r_low [0:QB-1];
    logic [DEN_W-1:0] r_den [0:QB-1];
    logic [NUM_W:0]   lim;

    // quotient beyond QB bits: flag and saturate later
    assign lim = (NUM_W+1)'({i_den, {QB{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num >> QB);
            r_low[0] <= i_num[QB-1:0];
            r_quo[0] <= '0;
            r_ovf[0] <= {1'b0, i_num} >= lim;
            r_den[0] <= i_den;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
        logic [REM_W-1:0] sh_rem;
        logic             take;

        assign sh_rem = {r_rem[s-1][REM_W-2:0], r_low[s-1][QB-1]};
        assign take   = sh_rem >= {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? sh_rem - {1'b0, r_den[s-1]} : sh_rem;
                r_quo[s] <= {r_quo[s-1][QB-2:0], take};
                r_ovf[s] <= r_ovf[s-1];
            end
        end

        if (s < QB) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[s] <= r_low[s-1] << 1;
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    assign o_quo    = r_quo[QB];
    assign o_rem_nz = |r_rem[QB];
    assign o_ovf    = r_ovf[QB];

endmodule

// File: rtl/tqtp_lane.sv
module tqtp_lane import tqtp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic signed [COORD_WIDTH-1:0] i_vz,
    input  t_mat                          i_mat,
    input  t_cam                          i_cam,
    output logic                          o_valid,
    output t_lane_res                     o_res
);

    localparam int PROD_W = MAT_W + COORD_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHR_W  = ACC_W - VERT_FRAC;
    localparam int PT_W   = ((SHR_W > 32) ? SHR_W : 32) + 1;
    localparam int NUM_W  = PT_W + OUT_W + 1;
    localparam int DEN_W  = PT_W - 1;
    localparam int SUM_W  = QUO_W + 3;

    typedef struct packed {
        logic valid;
        logic vis;
        logic neg_x;
        logic neg_y;
    } t_side;

    logic signed [COORD_WIDTH-1:0] v [3];
    logic signed [31:0]            off [3];
    logic signed [PROD_W-1:0]      r_prod [9];
    logic signed [ACC_W-1:0]       acc [3];
    logic signed [PT_W-1:0]        r_p [3];
    logic signed [PT_W-1:0]        nearp, farp;
    logic signed [PT_W:0]          nd;
    logic signed [NUM_W-1:0]       r_nx, r_ny;
    logic [NUM_W-1:0]              r_nd;
    logic [DEN_W-1:0]              r_den;
    logic                          r_vis3;
    logic                          r_v1, r_v2, r_v3;
    logic [NUM_W-1:0]              mag_x, mag_y;
    t_side                         r_side [0:QUO_W];
    logic [QUO_W-1:0]              quo_x, quo_y, quo_d;
    logic                          nz_x, nz_y, nz_d;
    logic                          ovf_x, ovf_y, ovf_d;
    logic signed [SUM_W-1:0]       sum_x, sum_y;
    logic                          r_vout;
    t_lane_res                     r_res, n_res;

    function automatic logic signed [QUO_W+1:0] floor_quo(
        input logic [QUO_W-1:0] q,
        input logic             nz,
        input logic             ovf,
        input logic             neg
    );
        logic signed [QUO_W+1:0] m;
        m = ovf ? {2'b01, {QUO_W{1'b0}}} : {2'b00, q} + (QUO_W+2)'(neg & nz);
        return neg ? -m : m;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SUM_W-1:0] x);
        logic signed [OUT_W-1:0] y;
        if (x > 32767) begin
            y = 16'sh7fff;
        end else if (x < -32768) begin
            y = 16'sh8000;
        end else begin
            y = x[OUT_W-1:0];
        end
        return y;
    endfunction

    assign v[0]   = i_vx;
    assign v[1]   = i_vy;
    assign v[2]   = i_vz;
    assign off[0] = i_cam.off_x;
    assign off[1] = i_cam.off_y;
    assign off[2] = i_cam.off_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // rotate: one product per matrix entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i*3+j] <= $signed(i_mat[i*3+j]) * v[j];
                end
            end
        end
    end

    // sum, floor to Q16.16 and translate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = ACC_W'(r_prod[i*3]) + ACC_W'(r_prod[i*3+1]) + ACC_W'(r_prod[i*3+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= PT_W'(acc[i] >>> VERT_FRAC) + PT_W'(off[i]);
            end
        end
    end

    assign nearp = PT_W'(i_cam.near_z);
    assign farp  = PT_W'(i_cam.far_z);
    assign nd    = (PT_W+1)'(r_p[2]) - (PT_W+1)'(nearp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx   <= $signed({1'b0, i_cam.focal_x}) * r_p[0];
            r_ny   <= $signed({1'b0, i_cam.focal_y}) * r_p[1];
            r_nd   <= (nd > 0) ? NUM_W'({nd[PT_W-1:0], {OUT_W{1'b0}}}) : '0;
            r_den  <= r_p[2][DEN_W-1:0];
            r_vis3 <= (r_p[2] > nearp) && (r_p[2] < farp) && (r_p[2] > 0);
        end
    end

    assign mag_x = r_nx[NUM_W-1] ? $unsigned(-r_nx) : $unsigned(r_nx);
    assign mag_y = r_ny[NUM_W-1] ? $unsigned(-r_ny) : $unsigned(r_ny);

    tqtp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QUO_W)) u_div_x (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_num    (mag_x),
        .i_den    (r_den),
        .o_quo    (quo_x),
        .o_rem_nz (nz_x),
        .o_ovf    (ovf_x)
    );

    tqtp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QUO_W)) u_div_y (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_num    (mag_y),
        .i_den    (r_den),
        .o_quo    (quo_y),
        .o_rem_nz (nz_y),
        .o_ovf    (ovf_y)
    );

    tqtp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QUO_W)) u_div_d (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_num    (r_nd),
        .i_den    (r_den),
        .o_quo    (quo_d),
        .o_rem_nz (nz_d),
        .o_ovf    (ovf_d)
    );

    // carry signs and flags alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QUO_W; s++) begin
                r_side[s] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= '{valid: r_v3, vis: r_vis3,
                           neg_x: r_nx[NUM_W-1], neg_y: r_ny[NUM_W-1]};
            for (int s = 1; s <= QUO_W; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_comb begin
        sum_x = $signed({{(SUM_W-OUT_W){1'b0}}, i_cam.cx})
              + SUM_W'(floor_quo(quo_x, nz_x, ovf_x, r_side[QUO_W].neg_x));
        sum_y = $signed({{(SUM_W-OUT_W){1'b0}}, i_cam.cy})
              - SUM_W'(floor_quo(quo_y, nz_y, ovf_y, r_side[QUO_W].neg_y));
        n_res.sx    = sat16(sum_x);
        n_res.sy    = sat16(sum_y);
        // depth remainder plays no part: numerator is never negative
        n_res.depth = (ovf_d || quo_d[QUO_W-1]) ? '1 : quo_d[OUT_W-1:0];
        n_res.vis   = r_side[QUO_W].vis & ~(nz_d & 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vout <= r_side[QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_vout;
    assign o_res   = r_res;

endmodule

// File: rtl/tqtp_merge.sv
module tqtp_merge import tqtp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_valid,
    input  t_lane_res [2:0]       i_res,
    input  logic                  i_m_ready,
    output logic                  o_en,
    output logic                  o_m_valid,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic                  o_m_user
);

    logic                  vis, d_valid, fire;
    logic [OUT_DATA_W-1:0] n_data;
    logic                  r_out_v, r_skid_v, r_out_user, r_skid_user;
    logic [OUT_DATA_W-1:0] r_out, r_skid;

    assign vis     = i_res[0].vis & i_res[1].vis & i_res[2].vis;
    assign d_valid = &i_valid;
    assign o_en    = ~r_skid_v;
    assign fire    = d_valid & o_en;

    // drop every field of a triangle that is not visible
    always_comb begin
        n_data = '0;
        for (int k = 0; k < 3; k++) begin
            if (vis) begin
                n_data[k*3*OUT_W +: OUT_W]           = i_res[k].sx;
                n_data[k*3*OUT_W + OUT_W +: OUT_W]   = i_res[k].sy;
                n_data[k*3*OUT_W + 2*OUT_W +: OUT_W] = i_res[k].depth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_ready) begin
            r_out_v  <= r_skid_v | fire;
            r_skid_v <= 1'b0;
        end else if (fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_ready) begin
            r_out      <= r_skid_v ? r_skid : n_data;
            r_out_user <= r_skid_v ? r_skid_user : vis;
        end else if (fire) begin
            r_skid      <= n_data;
            r_skid_user <= vis;
        end
    end

    assign o_m_valid = r_out_v;
    assign o_m_data  = r_out;
    assign o_m_user  = r_out_user;

endmodule

// File: rtl/triangle_quat_transform_project_core.sv
// Transforms one triangle per word: three vertices are rotated by the
// configured quaternion, translated, culled against the near and far planes
// and projected to screen x/y and normalised depth. One triangle is accepted
// every clock cycle unless stalled as below; the delay to each result is set
// mostly by the 17-step pipelined dividers in each of the three vertex lanes.
// A register write stops input while the rotation matrix is rebuilt; the
// output has a skid stage, so input stalls only once two results are waiting.
module triangle_quat_transform_project_core import tqtp_pkg::*; #(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_W        = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, zero pad
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // screen0_x, screen0_y, depth0, screen1_x .. depth2
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // visible
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_quat;
    t_cam                  r_cam;
    logic [1:0]            r_hold;
    logic                  cfg_fire, en, in_fire;
    t_mat                  mat;
    logic [2:0]            lane_valid;
    t_lane_res [2:0]       lane_res;

    assign o_cfg_ready     = 1'b1;
    assign cfg_fire        = i_cfg_valid & o_cfg_ready;
    assign o_s_axis_tready = en && (r_hold == 2'd0);
    assign in_fire         = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat <= QUAT_RESET;
            r_cam  <= '0;
        end else if (cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_QUAT: r_quat       <= i_cfg_data;
                CFG_OFF_X:    r_cam.off_x  <= i_cfg_data[31:0];
                CFG_OFF_Y:    r_cam.off_y  <= i_cfg_data[31:0];
                CFG_OFF_Z:    r_cam.off_z  <= i_cfg_data[31:0];
                CFG_FOCAL_X:  r_cam.focal_x <= i_cfg_data[15:0];
                CFG_FOCAL_Y:  r_cam.focal_y <= i_cfg_data[15:0];
                CFG_CENTER: begin
                    r_cam.cx <= i_cfg_data[31:16];
                    r_cam.cy <= i_cfg_data[15:0];
                end
                CFG_DEPTH: begin
                    r_cam.near_z <= i_cfg_data[63:32];
                    r_cam.far_z  <= i_cfg_data[31:0];
                end
                default: ;
            endcase
        end
    end

    // hold input while the matrix catches up with the quaternion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= CFG_HOLD;
        end else if (cfg_fire) begin
            r_hold <= CFG_HOLD;
        end else if (r_hold != 2'd0) begin
            r_hold <= r_hold - 2'd1;
        end
    end

    tqtp_rot u_rot (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_mat  (mat)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        tqtp_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (in_fire),
            .i_vx    (i_s_axis_tdata[(3*k)*COORD_WIDTH +: COORD_WIDTH]),
            .i_vy    (i_s_axis_tdata[(3*k+1)*COORD_WIDTH +: COORD_WIDTH]),
            .i_vz    (i_s_axis_tdata[(3*k+2)*COORD_WIDTH +: COORD_WIDTH]),
            .i_mat   (mat),
            .i_cam   (r_cam),
            .o_valid (lane_valid[k]),
            .o_res   (lane_res[k])
        );
    end

    tqtp_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (lane_valid),
        .i_res     (lane_res),
        .i_m_ready (i_m_axis_tready),
        .o_en      (en),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata),
        .o_m_user  (o_m_axis_tuser)
    );

endmodule

// File: rtl/tqtp_checker.sv
module tqtp_checker import tqtp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_cull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("culled triangle carries data");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_s_axis_tready)
        else $error("input taken right after a register write");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind triangle_quat_transform_project_core tqtp_checker u_tqtp_checker (.*);
